>>> sv/assert_macros.svh
// assertion helpers shared by the block, sampled on clk_i and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LLMB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property that must hold in the cycle after its trigger
`define LLMB_ASSERT_NEXT(label, pre, post, msg) \
  `LLMB_ASSERT(label, (pre) |=> (post), msg)

`endif

>>> sv/llmb_pkg.sv
`timescale 1ns / 1ps

package llmb_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned BIAS_W     = 32;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [SHIFT_W-1:0] OUT_SHIFT_RST   = 5'd15;
  localparam logic               BIAS_ENABLE_RST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_SHIFT   = 1'd0,
    CFG_BIAS_ENABLE = 1'd1
  } cfg_reg_e;

  // per-beat strobes from the pipeline control to every lane
  typedef struct packed {
    logic a_ld;    // capture product and start value
    logic first;   // beat in the product stage opens a run
    logic acc_en;  // product stage beat folds into the accumulator
    logic s_ld;    // closing beat: take a snapshot of the sum
    logic r_ld;    // snapshot moves through shift and rounding
  } lane_ctl_t;

endpackage

>>> sv/linear_layer_matmul_bias.sv
// a closing beat moves through the product, snapshot, rounded and output registers, and a stall can hold it
// one beat per cycle while in_stall_o is low, with a multiply-accumulate per lane in each such cycle
// with the output stalled, non-closing beats keep flowing; closing beats queue in two stages
// reset: accumulators clear, out_shift returns to 15 and bias_enable to 1
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_layer_matmul_bias #(
  parameter int unsigned ACC_WIDTH = 48
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [llmb_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [llmb_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [llmb_pkg::DATA_W-1:0]     act_i,
  input  logic signed [llmb_pkg::DATA_W-1:0]     w0_i,
  input  logic signed [llmb_pkg::DATA_W-1:0]     w1_i,
  input  logic signed [llmb_pkg::DATA_W-1:0]     w2_i,
  input  logic signed [llmb_pkg::DATA_W-1:0]     w3_i,
  input  logic signed [llmb_pkg::BIAS_W-1:0]     bias0_i,
  input  logic signed [llmb_pkg::BIAS_W-1:0]     bias1_i,
  input  logic signed [llmb_pkg::BIAS_W-1:0]     bias2_i,
  input  logic signed [llmb_pkg::BIAS_W-1:0]     bias3_i,
  input  logic                                   first_i,
  input  logic                                   last_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [llmb_pkg::DATA_W-1:0]     y0_o,
  output logic signed [llmb_pkg::DATA_W-1:0]     y1_o,
  output logic signed [llmb_pkg::DATA_W-1:0]     y2_o,
  output logic signed [llmb_pkg::DATA_W-1:0]     y3_o,
  output logic                                   saturated_o
);

  logic [llmb_pkg::SHIFT_W-1:0] out_shift_q, out_shift_d;
  logic                         bias_en_q, bias_en_d;

  logic a_vld_q, a_vld_d, a_first_q, a_last_q;
  logic s_vld_q, s_vld_d, r_vld_q, r_vld_d, o_vld_q, o_vld_d;
  logic out_rdy, r_rdy, s_rdy, a_adv, a_rdy, in_acc;
  logic s_ld, r_ld, o_ld;

  llmb_pkg::lane_ctl_t lane_ctl;

  logic signed [llmb_pkg::DATA_W-1:0] w_arr [llmb_pkg::LANES];
  logic signed [llmb_pkg::BIAS_W-1:0] bias_arr [llmb_pkg::LANES];
  logic signed [ACC_WIDTH-1:0]        r_arr [llmb_pkg::LANES];
  logic signed [llmb_pkg::DATA_W-1:0] y_arr [llmb_pkg::LANES];

  // configuration
  always_comb begin
    out_shift_d = out_shift_q;
    bias_en_d   = bias_en_q;
    if (cfg_we_i) begin
      unique case (llmb_pkg::cfg_reg_e'(cfg_idx_i))
        llmb_pkg::CFG_OUT_SHIFT:   out_shift_d = cfg_data_i;
        llmb_pkg::CFG_BIAS_ENABLE: bias_en_d   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_shift_q <= llmb_pkg::OUT_SHIFT_RST;
      bias_en_q   <= llmb_pkg::BIAS_ENABLE_RST;
    end else begin
      out_shift_q <= out_shift_d;
      bias_en_q   <= bias_en_d;
    end
  end

  // pipeline flow: product, snapshot, rounded, output
  assign out_rdy = !o_vld_q || !out_stall_i;
  assign r_rdy   = !r_vld_q || out_rdy;
  assign s_rdy   = !s_vld_q || r_rdy;
  assign a_adv   = a_vld_q && (!a_last_q || s_rdy);
  assign a_rdy   = !a_vld_q || a_adv;
  assign in_acc  = in_valid_i && a_rdy;
  assign s_ld    = a_adv && a_last_q;
  assign r_ld    = s_vld_q && r_rdy;
  assign o_ld    = r_vld_q && out_rdy;

  assign in_stall_o = !a_rdy;

  assign a_vld_d = in_acc ? 1'b1 : (a_adv ? 1'b0 : a_vld_q);
  assign s_vld_d = s_ld ? 1'b1 : (r_ld ? 1'b0 : s_vld_q);
  assign r_vld_d = r_ld ? 1'b1 : (o_ld ? 1'b0 : r_vld_q);
  assign o_vld_d = o_ld ? 1'b1 : (out_stall_i ? o_vld_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      a_first_q <= 1'b0;
      a_last_q  <= 1'b0;
      s_vld_q   <= 1'b0;
      r_vld_q   <= 1'b0;
      o_vld_q   <= 1'b0;
    end else begin
      a_vld_q <= a_vld_d;
      s_vld_q <= s_vld_d;
      r_vld_q <= r_vld_d;
      o_vld_q <= o_vld_d;
      if (in_acc) begin
        a_first_q <= first_i;
        a_last_q  <= last_i;
      end
    end
  end

  assign lane_ctl = '{a_ld: in_acc, first: a_first_q, acc_en: a_adv, s_ld: s_ld, r_ld: r_ld};

  assign w_arr[0]    = w0_i;
  assign w_arr[1]    = w1_i;
  assign w_arr[2]    = w2_i;
  assign w_arr[3]    = w3_i;
  assign bias_arr[0] = bias0_i;
  assign bias_arr[1] = bias1_i;
  assign bias_arr[2] = bias2_i;
  assign bias_arr[3] = bias3_i;

  for (genvar g = 0; g < llmb_pkg::LANES; g++) begin : g_lane
    llmb_lane #(
      .ACC_WIDTH(ACC_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (lane_ctl),
      .bias_en_i (bias_en_q),
      .shift_i   (out_shift_q),
      .act_i     (act_i),
      .w_i       (w_arr[g]),
      .bias_i    (bias_arr[g]),
      .r_o       (r_arr[g])
    );
  end

  llmb_merge #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_merge (
    .clk_i (clk_i),
    .ld_i  (o_ld),
    .r_i   (r_arr),
    .y_o   (y_arr),
    .sat_o (saturated_o)
  );

  assign out_valid_o = o_vld_q;
  assign y0_o        = y_arr[0];
  assign y1_o        = y_arr[1];
  assign y2_o        = y_arr[2];
  assign y3_o        = y_arr[3];

  `LLMB_ASSERT(stall_only_on_close, in_stall_o |-> (a_vld_q && a_last_q), "stall with no close")
  `LLMB_ASSERT_NEXT(close_snapshot, s_ld, s_vld_q, "closing beat left no snapshot")
  `LLMB_ASSERT_NEXT(rounded_held, (r_vld_q && !out_rdy), r_vld_q, "rounded result dropped")

endmodule

>>> sv/llmb_lane.sv
`timescale 1ns / 1ps

module llmb_lane #(
  parameter int unsigned ACC_WIDTH = 48
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  llmb_pkg::lane_ctl_t                    ctl_i,
  input  logic                                   bias_en_i,
  input  logic [llmb_pkg::SHIFT_W-1:0]           shift_i,
  input  logic signed [llmb_pkg::DATA_W-1:0]     act_i,
  input  logic signed [llmb_pkg::DATA_W-1:0]     w_i,
  input  logic signed [llmb_pkg::BIAS_W-1:0]     bias_i,
  output logic signed [ACC_WIDTH-1:0]            r_o
);

  logic signed [llmb_pkg::PROD_W-1:0] prod_q;
  logic signed [llmb_pkg::BIAS_W-1:0] base_q;
  logic signed [ACC_WIDTH-1:0]        acc_q, acc_d;
  logic signed [ACC_WIDTH-1:0]        s_q;
  logic signed [ACC_WIDTH-1:0]        shr;
  logic [ACC_WIDTH-1:0]               rnd_mask;
  logic                               rnd_bit;
  logic signed [ACC_WIDTH-1:0]        r_q, r_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.a_ld) begin
      prod_q <= act_i * w_i;
      base_q <= bias_en_i ? bias_i : '0;
    end
  end

  // wraps modulo 2^ACC_WIDTH
  assign acc_d = (ctl_i.first ? ACC_WIDTH'(base_q) : acc_q) + ACC_WIDTH'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.s_ld) begin
      s_q <= acc_d;
    end
  end

  // round half up: floor shift plus the last bit shifted out
  assign shr      = s_q >>> shift_i;
  assign rnd_mask = (shift_i == '0) ? '0
                  : ({{(ACC_WIDTH-1){1'b0}}, 1'b1} << (shift_i - 5'd1));
  assign rnd_bit  = |(s_q & rnd_mask);
  assign r_d      = shr + {{(ACC_WIDTH-1){1'b0}}, rnd_bit};

  always_ff @(posedge clk_i) begin
    if (ctl_i.r_ld) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

>>> sv/llmb_merge.sv
`timescale 1ns / 1ps

module llmb_merge #(
  parameter int unsigned ACC_WIDTH = 48
) (
  input  logic                               clk_i,
  input  logic                               ld_i,
  input  logic signed [ACC_WIDTH-1:0]        r_i [llmb_pkg::LANES],
  output logic signed [llmb_pkg::DATA_W-1:0] y_o [llmb_pkg::LANES],
  output logic                               sat_o
);

  localparam int unsigned HiW = ACC_WIDTH - llmb_pkg::DATA_W + 1;

  logic signed [llmb_pkg::DATA_W-1:0] y_d [llmb_pkg::LANES];
  logic [llmb_pkg::LANES-1:0]         clip;
  logic signed [llmb_pkg::DATA_W-1:0] y_q [llmb_pkg::LANES];
  logic                               sat_q;

  always_comb begin
    for (int i = 0; i < llmb_pkg::LANES; i++) begin
      // in range when the top bits down to the q1.15 sign all agree
      clip[i] = !((r_i[i][ACC_WIDTH-1 -: HiW] == '0) || (r_i[i][ACC_WIDTH-1 -: HiW] == '1));
      if (!clip[i]) begin
        y_d[i] = r_i[i][llmb_pkg::DATA_W-1:0];
      end else if (r_i[i][ACC_WIDTH-1]) begin
        y_d[i] = {1'b1, {(llmb_pkg::DATA_W-1){1'b0}}};
      end else begin
        y_d[i] = {1'b0, {(llmb_pkg::DATA_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      y_q   <= y_d;
      sat_q <= |clip;
    end
  end

  assign y_o   = y_q;
  assign sat_o = sat_q;

endmodule
